// ----- hw/rtl/sqm_pkg.sv -----
// ---------------------------------------------------------------------------
// sqm_pkg: shared types and constants
// Codes, constants and the mark decision used by the shadow queue marker.
// ---------------------------------------------------------------------------
package sqm_pkg;

   localparam logic [16:0] ONE_Q16       = 17'h10000;
   localparam logic [10:0] BACKLOG_BYTES = 11'd1500;

   localparam logic [1:0] VERDICT_PASS      = 2'd0;
   localparam logic [1:0] VERDICT_MARK      = 2'd1;
   localparam logic [1:0] VERDICT_DROP_FULL = 2'd2;
   localparam logic [1:0] VERDICT_DROP_RAND = 2'd3;

   localparam logic [1:0] ECN_NOT_ECT = 2'd0;
   localparam logic [1:0] ECN_CE      = 2'd3;

   localparam int unsigned CSR_ADDR_W = 3;
   localparam logic [CSR_ADDR_W-1:0] CSR_CAPACITY = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_INTERVAL = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_MAX_PROB = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_WEIGHT   = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_LINK     = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_ECN_EN   = 3'd5;

   typedef struct packed {
      logic [1:0] verdict;
      logic [1:0] ecn;
      logic       flag;
   } decision_type;

   function automatic logic [16:0] clamp_one(input logic [16:0] v);
      return (v > ONE_Q16) ? ONE_Q16 : v;
   endfunction

   function automatic decision_type decide(input logic [16:0] prob,
                                           input logic [15:0] rnd,
                                           input logic [1:0]  ecn,
                                           input logic        en,
                                           input logic        flag);
      decision_type d;
      d.verdict = VERDICT_PASS;
      d.ecn     = ecn;
      d.flag    = flag;
      if ({1'b0, rnd} < prob) begin
         if (en && ecn != ECN_NOT_ECT) begin
            d.verdict = VERDICT_MARK;
            if (flag && ecn != ECN_CE) begin
               d.ecn  = ECN_CE;
               d.flag = 1'b0;
            end else if (ecn == ECN_CE) begin
               d.flag = 1'b1;
            end else begin
               d.ecn = ECN_CE;
            end
         end else begin
            d.verdict = VERDICT_DROP_RAND;
         end
      end
      return d;
   endfunction

endpackage

// ----- hw/rtl/sqm_mul.sv -----
// ---------------------------------------------------------------------------
// sqm_mul: shared multiplier
// 32 x 32 unsigned multiply with a registered product.
// ---------------------------------------------------------------------------
module sqm_mul (
   input  logic        clock,
   input  logic [31:0] op_a,
   input  logic [31:0] op_b,
   output logic [63:0] prod_ff
);
   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
   end
endmodule

// ----- hw/rtl/sqm_div.sv -----
// ---------------------------------------------------------------------------
// sqm_div: restoring divider
// One quotient bit a cycle, 17 bits, most significant first.
// ---------------------------------------------------------------------------
module sqm_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] num,
   input  logic [63:0] den,
   output logic [16:0] quot_ff,
   output logic        done_ff
);
   logic [63:0] rem_ff, rem_in;
   logic [63:0] den_ff;
   logic [4:0]  bit_ff;
   logic        busy_ff;
   logic [63:0] shifted;
   logic [16:0] quot_in;
   logic        take;

   always_comb begin
      shifted = rem_ff >> bit_ff;
      take    = (shifted >= den_ff);
      rem_in  = take ? (rem_ff - (den_ff << bit_ff)) : rem_ff;
      quot_in = quot_ff | (take ? (17'd1 << bit_ff) : 17'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            bit_ff  <= 5'd16;
            rem_ff  <= num;
            den_ff  <= den;
            quot_ff <= 17'd0;
         end else if (busy_ff) begin
            rem_ff  <= rem_in;
            quot_ff <= quot_in;
            bit_ff  <= bit_ff - 5'd1;
            if (bit_ff == 5'd0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end
endmodule

// ----- hw/rtl/shadow_queue_ecn_marker.sv -----
// A request is taken in S_IDLE and checked in S_EVAL. A queue-full drop or a packet
// inside the interval goes straight to S_PUSH; an update packet runs the multiplier
// states S_M0 to S_M8, the 17-step divider in S_DIV when the quotient is needed, then
// S_FIN and S_PUSH. Takes no new request before the last is pushed: not ready while a
// packet is in work, and a stalled response holds the sequencer.
// Synchronous active-high reset loads CSR defaults, clears sequencer and rate state.
// ---------------------------------------------------------------------------
// shadow_queue_ecn_marker: shadow queue AQM with ECN marking
// Sequencer around one multiplier and one divider computing EWMA rate and
// marking probability per interval.
// ---------------------------------------------------------------------------
module shadow_queue_ecn_marker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_pkt_bytes,
   input  logic [15:0] req_queue_len,
   input  logic [47:0] req_now_ticks,
   input  logic [1:0]  req_ecn_in,
   input  logic [15:0] req_random_q16,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_verdict,
   output logic [1:0]  rsp_ecn_out,
   output logic        rsp_prob_updated,
   output logic [16:0] rsp_mark_prob_q16,
   output logic [31:0] rsp_avg_rate_bytes,
   input  logic        csr_we,
   input  logic [sqm_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [31:0] csr_wdata
);
   import sqm_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_EVAL, S_M0, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7, S_M8,
      S_DIV, S_FIN, S_PUSH
   } state_type;

   state_type state_ff;

   logic [15:0] cap_ff;
   logic [31:0] interval_ff;
   logic [16:0] maxp_raw_ff, wt_raw_ff;
   logic [31:0] link_ff;
   logic        ecn_en_ff;

   logic [15:0] bytes_ff, qlen_ff, rnd_ff;
   logic [47:0] now_ff;
   logic [1:0]  ecn_ff;

   logic [31:0] ib_ff;
   logic [47:0] avg_ff;
   logic [47:0] last_ff;
   logic        flag_ff;

   logic [47:0] elapsed_ff;
   logic [63:0] acc_ff;
   logic [79:0] den_ff;
   logic [63:0] num_ff;
   logic [16:0] prob_ff;

   logic [1:0]  res_verdict_ff, res_ecn_ff;
   logic        res_upd_ff;
   logic [16:0] res_prob_ff;

   logic        out_valid_ff;
   logic [1:0]  out_verdict_ff, out_ecn_ff;
   logic        out_upd_ff;
   logic [16:0] out_prob_ff;
   logic [31:0] out_avg_ff;

   logic [31:0] op_a, op_b;
   logic [63:0] mul_ff;
   logic        div_start;
   logic [16:0] div_quot;
   logic        div_done;

   logic [16:0] maxp, wt, omw;
   logic [32:0] ib_sum;
   logic [31:0] ib_sat;
   logic [47:0] elapsed;
   logic [63:0] num_in;
   logic [32:0] ql_sum;
   decision_type dec;

   always_comb begin
      maxp    = clamp_one(maxp_raw_ff);
      wt      = clamp_one(wt_raw_ff);
      omw     = ONE_Q16 - wt;
      ib_sum  = {1'b0, ib_ff} + {17'd0, bytes_ff};
      ib_sat  = ib_sum[32] ? 32'hFFFF_FFFF : ib_sum[31:0];
      ql_sum  = {1'b0, ib_ff} + {1'b0, mul_ff[31:0]};
      elapsed = now_ff - last_ff;
      num_in  = num_ff + {mul_ff[31:0], 32'd0};
      dec     = decide(prob_ff, rnd_ff, ecn_ff, ecn_en_ff, flag_ff);
      div_start = (state_ff == S_M8) && (den_ff != 80'd0) && (den_ff[79:64] == 16'd0)
                  && ({16'd0, avg_ff} < den_ff[63:0]);
   end

   // operand selection for the shared multiplier
   always_comb begin
      unique case (state_ff)
         S_M0: begin op_a = {16'd0, qlen_ff};          op_b = {21'd0, BACKLOG_BYTES}; end
         S_M1: begin op_a = avg_ff[31:0];              op_b = {15'd0, omw};           end
         S_M2: begin op_a = {16'd0, avg_ff[47:32]};    op_b = {15'd0, omw};           end
         S_M3: begin op_a = ib_ff;                     op_b = {15'd0, wt};            end
         S_M4: begin op_a = link_ff;                   op_b = elapsed_ff[31:0];       end
         S_M5: begin op_a = link_ff;                   op_b = {16'd0, elapsed_ff[47:32]}; end
         S_M6: begin op_a = avg_ff[31:0];              op_b = {15'd0, maxp};          end
         S_M7: begin op_a = {16'd0, avg_ff[47:32]};    op_b = {15'd0, maxp};          end
         default: begin op_a = 32'd0; op_b = 32'd0; end
      endcase
   end

   sqm_mul u_mul (
      .clock   (clock),
      .op_a    (op_a),
      .op_b    (op_b),
      .prod_ff (mul_ff)
   );

   sqm_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .num     (num_in),
      .den     (den_ff[63:0]),
      .quot_ff (div_quot),
      .done_ff (div_done)
   );

   assign req_ready          = (state_ff == S_IDLE);
   assign rsp_valid          = out_valid_ff;
   assign rsp_verdict        = out_verdict_ff;
   assign rsp_ecn_out        = out_ecn_ff;
   assign rsp_prob_updated   = out_upd_ff;
   assign rsp_mark_prob_q16  = out_prob_ff;
   assign rsp_avg_rate_bytes = out_avg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cap_ff       <= 16'd100;
         interval_ff  <= 32'd1000;
         maxp_raw_ff  <= 17'd6554;
         wt_raw_ff    <= 17'd3277;
         link_ff      <= 32'd8192;
         ecn_en_ff    <= 1'b1;
         ib_ff        <= 32'd0;
         avg_ff       <= 48'd0;
         last_ff      <= 48'd0;
         flag_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_addr)
               CSR_CAPACITY: cap_ff      <= csr_wdata[15:0];
               CSR_INTERVAL: interval_ff <= csr_wdata;
               CSR_MAX_PROB: maxp_raw_ff <= csr_wdata[16:0];
               CSR_WEIGHT:   wt_raw_ff   <= csr_wdata[16:0];
               CSR_LINK:     link_ff     <= csr_wdata;
               CSR_ECN_EN:   ecn_en_ff   <= csr_wdata[0];
               default: ;
            endcase
         end

         if (out_valid_ff && rsp_ready && state_ff != S_PUSH) out_valid_ff <= 1'b0;

         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  bytes_ff <= req_pkt_bytes;
                  qlen_ff  <= req_queue_len;
                  now_ff   <= req_now_ticks;
                  ecn_ff   <= req_ecn_in;
                  rnd_ff   <= req_random_q16;
                  state_ff <= S_EVAL;
               end
            end
            S_EVAL: begin
               res_ecn_ff  <= ecn_ff;
               res_upd_ff  <= 1'b0;
               res_prob_ff <= 17'd0;
               if (qlen_ff >= cap_ff) begin
                  res_verdict_ff <= VERDICT_DROP_FULL;
                  state_ff       <= S_PUSH;
               end else begin
                  ib_ff      <= ib_sat;
                  elapsed_ff <= elapsed;
                  if (elapsed >= {16'd0, interval_ff}) begin
                     state_ff <= S_M0;
                  end else begin
                     // probability is zero, so never marked
                     res_verdict_ff <= VERDICT_PASS;
                     state_ff       <= S_PUSH;
                  end
               end
            end
            S_M0: state_ff <= S_M1;
            S_M1: begin
               ib_ff    <= ql_sum[32] ? 32'hFFFF_FFFF : ql_sum[31:0];
               state_ff <= S_M2;
            end
            S_M2: begin
               acc_ff   <= mul_ff;
               state_ff <= S_M3;
            end
            S_M3: begin
               acc_ff   <= acc_ff + {mul_ff[31:0], 32'd0};
               state_ff <= S_M4;
            end
            S_M4: begin
               acc_ff   <= acc_ff + {mul_ff[47:0], 16'd0};
               state_ff <= S_M5;
            end
            S_M5: begin
               avg_ff   <= acc_ff[63:16];
               den_ff   <= {16'd0, mul_ff};
               state_ff <= S_M6;
            end
            S_M6: begin
               den_ff   <= den_ff + {mul_ff[47:0], 32'd0};
               state_ff <= S_M7;
            end
            S_M7: begin
               num_ff   <= mul_ff;
               state_ff <= S_M8;
            end
            S_M8: begin
               num_ff <= num_in;
               if (den_ff == 80'd0) begin
                  prob_ff  <= ONE_Q16;
                  state_ff <= S_FIN;
               end else if (den_ff[79:64] != 16'd0) begin
                  // quotient reads as zero when the denominator is beyond 64 bits
                  prob_ff  <= (maxp == 17'd0) ? ONE_Q16 : 17'd0;
                  state_ff <= S_FIN;
               end else if ({16'd0, avg_ff} >= den_ff[63:0]) begin
                  prob_ff  <= ONE_Q16;
                  state_ff <= S_FIN;
               end else begin
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               if (div_done) begin
                  prob_ff  <= (div_quot >= maxp) ? ONE_Q16 : div_quot;
                  state_ff <= S_FIN;
               end
            end
            S_FIN: begin
               res_verdict_ff <= dec.verdict;
               res_ecn_ff     <= dec.ecn;
               res_upd_ff     <= 1'b1;
               res_prob_ff    <= prob_ff;
               flag_ff        <= dec.flag;
               last_ff        <= now_ff;
               ib_ff          <= 32'd0;
               state_ff       <= S_PUSH;
            end
            S_PUSH: begin
               if (!out_valid_ff || rsp_ready) begin
                  out_valid_ff   <= 1'b1;
                  out_verdict_ff <= res_verdict_ff;
                  out_ecn_ff     <= res_ecn_ff;
                  out_upd_ff     <= res_upd_ff;
                  out_prob_ff    <= res_prob_ff;
                  out_avg_ff     <= avg_ff[47:16];
                  state_ff       <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

// ----- hw/rtl/sqm_checker.sv -----
// ---------------------------------------------------------------------------
// sqm_checker: port-level checks
// Watches the marker's ports for handshake and result consistency.
// ---------------------------------------------------------------------------
module sqm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_verdict,
   input logic        rsp_prob_updated,
   input logic [16:0] rsp_mark_prob_q16
);
   import sqm_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_verdict))
      else $error("result changed while stalled");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_verdict == VERDICT_DROP_FULL |-> !rsp_prob_updated)
      else $error("queue-full drop reported an update");

   a_noupd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_prob_updated |-> rsp_mark_prob_q16 == 17'd0)
      else $error("probability without update");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_mark_prob_q16[16] && rsp_mark_prob_q16[15:0] != 16'd0))
      else $error("probability above one");
endmodule

bind shadow_queue_ecn_marker sqm_checker u_sqm_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_verdict       (rsp_verdict),
   .rsp_prob_updated  (rsp_prob_updated),
   .rsp_mark_prob_q16 (rsp_mark_prob_q16)
);

// ----- test/tb_top.sv -----
// ---------------------------------------------------------------------------
// tb_top: shadow queue ECN marker testbench
// Drives packet requests through the valid/ready port with random gaps,
// predicts each verdict, ECN code, update flag, probability and rate from
// an internal copy of the marker state, and checks every response in order.
// ---------------------------------------------------------------------------
module tb_top;
   import sqm_pkg::*;

   localparam int LIMIT_CYCLES = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [15:0] req_pkt_bytes = '0;
   logic [15:0] req_queue_len = '0;
   logic [47:0] req_now_ticks = '0;
   logic [1:0]  req_ecn_in = '0;
   logic [15:0] req_random_q16 = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_verdict;
   logic [1:0]  rsp_ecn_out;
   logic        rsp_prob_updated;
   logic [16:0] rsp_mark_prob_q16;
   logic [31:0] rsp_avg_rate_bytes;
   logic        csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [31:0] csr_wdata = '0;

   shadow_queue_ecn_marker u_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   typedef struct packed {
      logic [15:0] bytes;
      logic [15:0] qlen;
      logic [47:0] now;
      logic [1:0]  ecn;
      logic [15:0] rnd;
   } pkt_type;

   typedef struct packed {
      logic [1:0]  verdict;
      logic [1:0]  ecn;
      logic        upd;
      logic [16:0] prob;
      logic [31:0] rate;
   } verdict_type;

   // directed row: packet, and a typed-in result where it is obvious
   typedef struct packed {
      pkt_type     p;
      logic        fixed;
      verdict_type v;
   } row_type;

   // marker registers and state as the checker sees them
   logic [15:0] m_cap;
   logic [31:0] m_intv;
   logic [16:0] m_maxp, m_wt;
   logic [31:0] m_link;
   logic        m_ecn_en;
   logic [31:0] m_bytes;
   logic [47:0] m_avg;
   logic [47:0] m_last;
   logic        m_flag;

   verdict_type verdicts_due[$];
   int  errors = 0, sent = 0, checked = 0, updates = 0, marks = 0;
   int  cycles = 0;
   bit  hold_off = 1'b0;
   bit  no_gaps = 1'b0;

   function automatic logic [31:0] add_sat(logic [31:0] a, logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   function automatic logic [16:0] mark_prob(logic [47:0] elapsed);
      logic [16:0] mp;
      logic [79:0] den;
      logic [64:0] num;
      logic [16:0] q;
      mp  = (m_maxp > ONE_Q16) ? ONE_Q16 : m_maxp;
      den = 80'(m_link) * 80'(elapsed);
      if (den == 0) return ONE_Q16;
      // a denominator beyond 64 bits gives a zero quotient
      if (den[79:64] != 0) return (mp == 17'd0) ? ONE_Q16 : 17'd0;
      if (64'(m_avg) >= den[63:0]) return ONE_Q16;
      num = 65'(mp) * 65'(m_avg);
      q   = 17'(num / den[63:0]);
      return (q >= mp) ? ONE_Q16 : q;
   endfunction

   function automatic verdict_type predict_verdict(pkt_type p);
      verdict_type r;
      logic [47:0] elapsed;
      logic [16:0] w;
      logic [95:0] mix;
      r = '0;
      r.ecn = p.ecn;
      if (p.qlen >= m_cap) begin
         r.verdict = VERDICT_DROP_FULL;
      end else begin
         m_bytes = add_sat(m_bytes, 32'(p.bytes));
         elapsed = p.now - m_last;
         if (elapsed >= 48'(m_intv)) begin
            w = (m_wt > ONE_Q16) ? ONE_Q16 : m_wt;
            m_bytes = add_sat(m_bytes, 32'(p.qlen) * 32'd1500);
            mix = 96'(ONE_Q16 - w) * 96'(m_avg) + 96'(w) * {48'd0, m_bytes, 16'd0};
            m_avg = 48'(mix >> 16);
            r.prob = mark_prob(elapsed);
            r.upd = 1'b1;
            m_last = p.now;
            m_bytes = '0;
         end
         if ({1'b0, p.rnd} < r.prob) begin
            if (m_ecn_en && p.ecn != ECN_NOT_ECT) begin
               r.verdict = VERDICT_MARK;
               if (m_flag && p.ecn != ECN_CE) begin
                  r.ecn = ECN_CE;
                  m_flag = 1'b0;
               end else if (p.ecn == ECN_CE) begin
                  m_flag = 1'b1;
               end else begin
                  r.ecn = ECN_CE;
               end
            end else begin
               r.verdict = VERDICT_DROP_RAND;
            end
         end
      end
      r.rate = m_avg[47:16];
      return r;
   endfunction

   task automatic csr_write(logic [CSR_ADDR_W-1:0] idx, logic [31:0] val);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_CAPACITY: m_cap    = val[15:0];
         CSR_INTERVAL: m_intv   = val;
         CSR_MAX_PROB: m_maxp   = val[16:0];
         CSR_WEIGHT:   m_wt     = val[16:0];
         CSR_LINK:     m_link   = val;
         CSR_ECN_EN:   m_ecn_en = val[0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // valid stays up after acceptance until the next request or an idle gap
   task automatic send_packet(pkt_type p, logic fixed, verdict_type v);
      verdict_type pv;
      if (!no_gaps && $urandom_range(99) < 26) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 26);
      end
      req_valid      <= 1'b1;
      req_pkt_bytes  <= p.bytes;
      req_queue_len  <= p.qlen;
      req_now_ticks  <= p.now;
      req_ecn_in     <= p.ecn;
      req_random_q16 <= p.rnd;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pv = predict_verdict(p);
      verdicts_due.push_back(fixed ? v : pv);
      sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (verdicts_due.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // response side: random stalls, one long hold-off on request
   always @(posedge clock) begin
      if (reset)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= !hold_off && (no_gaps || $urandom_range(99) >= 26);
   end

   always @(posedge clock) begin
      verdict_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (verdicts_due.size() == 0) begin
            $display("%0t: unexpected response verdict %0d", $time, rsp_verdict);
            errors++;
         end else begin
            e = verdicts_due.pop_front();
            checked++;
            if (rsp_prob_updated) updates++;
            if (rsp_verdict == VERDICT_MARK) marks++;
            if (rsp_verdict !== e.verdict) begin
               $display("%0t: verdict exp %0d got %0d", $time, e.verdict, rsp_verdict);
               errors++;
            end
            if (rsp_ecn_out !== e.ecn) begin
               $display("%0t: ecn_out exp %0d got %0d", $time, e.ecn, rsp_ecn_out);
               errors++;
            end
            if (rsp_prob_updated !== e.upd) begin
               $display("%0t: prob_updated exp %0d got %0d", $time, e.upd,
                        rsp_prob_updated);
               errors++;
            end
            if (rsp_mark_prob_q16 !== e.prob) begin
               $display("%0t: mark_prob exp %0d got %0d", $time, e.prob,
                        rsp_mark_prob_q16);
               errors++;
            end
            if (rsp_avg_rate_bytes !== e.rate) begin
               $display("%0t: avg_rate exp %0d got %0d", $time, e.rate,
                        rsp_avg_rate_bytes);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d responses outstanding", cycles,
                  verdicts_due.size());
         $display("** shadow_queue_ecn_marker: FAILED **");
         $finish;
      end
   end

   function automatic pkt_type rand_packet(logic [47:0] base);
      pkt_type p;
      p.bytes = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(64, 1500));
      p.qlen  = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, m_cap + 8));
      p.now   = ($urandom_range(49) == 0) ? {16'($urandom), 32'($urandom)}
                                          : base;
      p.ecn   = 2'($urandom);
      p.rnd   = ($urandom_range(1) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8000));
      return p;
   endfunction

   // stalls the response side for a long stretch, counted here
   task automatic long_hold();
      hold_off = 1'b1;
      repeat (300) @(posedge clock);
      hold_off = 1'b0;
   endtask

   row_type rows[] = '{
      // capacity 100 after reset: queue full, nothing else touched
      '{'{16'hFFFF, 16'd100, 48'd5, 2'd1, 16'd0}, 1'b1,
        '{VERDICT_DROP_FULL, 2'd1, 1'b0, 17'd0, 32'd0}},
      '{'{16'd0, 16'hFFFF, 48'hFFFF_FFFF_FFFF, 2'd3, 16'hFFFF}, 1'b1,
        '{VERDICT_DROP_FULL, 2'd3, 1'b0, 17'd0, 32'd0}},
      // before the interval: no update, pass untouched
      '{'{16'd1500, 16'd0, 48'd10, 2'd2, 16'd0}, 1'b1,
        '{VERDICT_PASS, 2'd2, 1'b0, 17'd0, 32'd0}},
      '{'{16'hFFFF, 16'd99, 48'd999, 2'd0, 16'd0}, 1'b1,
        '{VERDICT_PASS, 2'd0, 1'b0, 17'd0, 32'd0}},
      '{'{16'd64, 16'd50, 48'd1000, 2'd2, 16'd0}, 1'b0, '0},
      '{'{16'd64, 16'd99, 48'd2000, 2'd1, 16'd0}, 1'b0, '0},
      '{'{16'd64, 16'd99, 48'd3000, 2'd3, 16'd0}, 1'b0, '0},
      '{'{16'd64, 16'd99, 48'd4000, 2'd2, 16'd0}, 1'b0, '0},
      '{'{16'd64, 16'd99, 48'd5000, 2'd0, 16'd0}, 1'b0, '0},
      // time running backwards reads as a long interval
      '{'{16'd100, 16'd10, 48'd20, 2'd1, 16'hFFFF}, 1'b0, '0},
      '{'{16'd100, 16'd10, 48'hFFFF_FFFF_FFFF, 2'd3, 16'd0}, 1'b0, '0},
      '{'{16'd100, 16'd0, 48'h8000_0000_0000, 2'd1, 16'd0}, 1'b0, '0}
   };

   initial begin
      logic [47:0] clk_now;
      pkt_type p;
      m_cap = 16'd100; m_intv = 32'd1000; m_maxp = 17'd6554; m_wt = 17'd3277;
      m_link = 32'd8192; m_ecn_en = 1'b1;
      m_bytes = '0; m_avg = '0; m_last = '0; m_flag = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) send_packet(rows[i].p, rows[i].fixed, rows[i].v);
      drain();

      // heavy marking: tiny link, zero interval, then the extremes
      csr_write(CSR_LINK, 32'd1);
      csr_write(CSR_INTERVAL, 32'd0);
      csr_write(CSR_MAX_PROB, 32'h1FFFF);
      csr_write(CSR_WEIGHT, 32'h1FFFF);
      for (int i = 0; i < 6; i++)
         send_packet('{16'd1500, 16'd5, 48'd6000 + 48'(i), 2'(i), 16'd0}, 1'b0, '0);
      drain();
      csr_write(CSR_ECN_EN, 32'd0);
      send_packet('{16'd0, 16'd0, 48'd0, 2'd2, 16'd0}, 1'b0, '0);
      drain();
      csr_write(CSR_CAPACITY, 32'd0);
      send_packet('{16'd0, 16'd0, 48'd9, 2'd1, 16'd0}, 1'b1,
                  '{VERDICT_DROP_FULL, 2'd1, 1'b0, 17'd0, 32'(m_avg[47:16])});
      drain();

      clk_now = 48'd10000;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               csr_write(CSR_CAPACITY, 32'd200); csr_write(CSR_INTERVAL, 32'd500);
               csr_write(CSR_MAX_PROB, 32'd30000); csr_write(CSR_WEIGHT, 32'd16384);
               csr_write(CSR_LINK, 32'd65536); csr_write(CSR_ECN_EN, 32'd1);
            end
            1: begin
               csr_write(CSR_MAX_PROB, 32'd0); csr_write(CSR_WEIGHT, 32'd0);
               csr_write(CSR_CAPACITY, 32'hFFFF);
            end
            2: begin
               csr_write(CSR_MAX_PROB, 32'd65536); csr_write(CSR_WEIGHT, 32'd65536);
               csr_write(CSR_LINK, 32'hFFFF_FFFF); csr_write(CSR_INTERVAL, 32'd50);
               csr_write(CSR_CAPACITY, 32'd100);
            end
            3: begin
               csr_write(CSR_LINK, 32'd4096); csr_write(CSR_ECN_EN, 32'd0);
               csr_write(CSR_MAX_PROB, 32'd20000); csr_write(CSR_WEIGHT, 32'd3277);
               csr_write(CSR_INTERVAL, 32'hFFFF_FFFF);
            end
            4: begin
               csr_write(CSR_INTERVAL, 32'd200); csr_write(CSR_ECN_EN, 32'd1);
               csr_write(CSR_LINK, 32'd2048);
            end
            default: begin
               csr_write(CSR_INTERVAL, 32'd1); csr_write(CSR_MAX_PROB, 32'd50000);
            end
         endcase
         no_gaps = (phase == 4);
         if (phase == 1) fork long_hold(); join_none
         for (int i = 0; i < 140; i++) begin
            clk_now = clk_now + 48'($urandom_range(0, 120));
            p = rand_packet(clk_now);
            send_packet(p, 1'b0, '0);
         end
         drain();
      end
      no_gaps = 1'b0;
      drain();

      $display("%0d packets sent, %0d responses checked, %0d interval updates, %0d marks",
               sent, checked, updates, marks);
      $display("register settings covered extremes of capacity, interval, weight and max");
      if (errors == 0 && verdicts_due.size() == 0)
         $display("** shadow_queue_ecn_marker: PASSED **");
      else
         $display("** shadow_queue_ecn_marker: FAILED **");
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/sqm_pkg.sv
hw/rtl/sqm_mul.sv
hw/rtl/sqm_div.sv
hw/rtl/shadow_queue_ecn_marker.sv
hw/rtl/sqm_checker.sv
test/tb_top.sv
